// ----- src/acld_pkg.sv -----
`default_nettype none

package acld_pkg;

	// Default line buffer depth in bytes.
	localparam int BUFFER_DEPTH_DEF = 16;

	// Line control characters.
	localparam logic [7:0] CH_LF = 8'h0a;
	localparam logic [7:0] CH_CR = 8'h0d;

	// Command table: entry 0 is the sensor command, entries 1 to 4 the pin commands.
	localparam int NUM_CMDS   = 5;
	localparam int SENSOR_LEN = 8;
	localparam int PIN_LEN    = 6;
	localparam int NUM_PINS   = 4;

	// Sensor command text, first character in the top byte.
	localparam logic [63:0] SENSOR_CMD = 64'h41542B4448543131;

	// Pin command texts in pin bit order.
	localparam logic [47:0] PIN_CMD [NUM_PINS] = '{"AT+PB4", "AT+PB5", "AT+PC3", "AT+PC4"};

	// Kinds of result word.
	typedef enum logic [1:0] {
		EV_SENSOR = 2'd0,
		EV_PIN    = 2'd1,
		EV_ECHO   = 2'd2
	} ev_kind_t;

	// Classification that the front end attaches to each received byte.
	typedef enum logic [1:0] {
		JOB_STORE,
		JOB_SENSOR,
		JOB_PIN,
		JOB_ECHO
	} job_kind_t;

	// One queued job: the received byte, its class and the pin states after it.
	typedef struct packed {
		job_kind_t  kind;
		logic [3:0] pins;
		logic [7:0] data;
	} job_t;

	// Back end sequencer states.
	typedef enum logic {
		BK_IDLE,
		BK_ECHO
	} back_state_t;

	// Character idx of command cmd.
	function automatic logic [7:0] cmd_char(input logic [2:0] cmd, input logic [2:0] idx);
		logic [7:0] r;
		r = 8'h00;
		if (cmd == 3'd0) begin
			r = SENSOR_CMD[63 - 8 * int'(idx) -: 8];
		end else if (int'(idx) < PIN_LEN && int'(cmd) <= NUM_PINS) begin
			r = PIN_CMD[int'(cmd) - 1][47 - 8 * int'(idx) -: 8];
		end
		return r;
	endfunction

	// Length of command cmd in characters.
	function automatic int cmd_len(input logic [2:0] cmd);
		return (cmd == 3'd0) ? SENSOR_LEN : PIN_LEN;
	endfunction

endpackage

`default_nettype wire

// ----- src/acld_if.sv -----
`default_nettype none

// Channel of received bytes.
interface acld_rx_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

// Channel of result words.
interface acld_ev_if;
	logic       valid;
	logic       ready;
	logic [1:0] event_kind;
	logic [7:0] echo_byte;
	logic       last;
	logic [3:0] pin_states;

	modport source (output valid, output event_kind, output echo_byte, output last,
		output pin_states, input ready);
	modport sink (input valid, input event_kind, input echo_byte, input last,
		input pin_states, output ready);
endinterface

`default_nettype wire

// ----- src/acld_fifo.sv -----
`default_nettype none

module acld_fifo
	import acld_pkg::*;
#(
	parameter int WIDTH = 16
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire logic [WIDTH-1:0] push_data,
	output logic                  full,
	input  wire logic             pop,
	output logic [WIDTH-1:0]      pop_data,
	output logic                  not_empty
);

	logic [WIDTH-1:0] entry_q [2];
	logic             wr_ptr_q;
	logic             rd_ptr_q;
	logic [1:0]       count_q;

	assign full      = (count_q == 2'd2);
	assign not_empty = (count_q != 2'd0);
	assign pop_data  = entry_q[rd_ptr_q];

	// Pointers and occupancy.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

`default_nettype wire

// ----- src/acld_front.sv -----
`default_nettype none

module acld_front
	import acld_pkg::*;
#(
	parameter  int BUFFER_DEPTH = BUFFER_DEPTH_DEF,
	localparam int PW           = $clog2(BUFFER_DEPTH),
	localparam int FW           = $clog2(BUFFER_DEPTH + 1)
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	acld_rx_if.sink            rx,
	output logic               push,
	output job_t               push_job,
	output logic [PW-1:0]      push_pos,
	input  wire logic          full
);

	logic [FW-1:0]       fill_q;
	logic                prev_cr_q;
	logic [NUM_CMDS-1:0] match_q;
	logic [3:0]          pins_q;

	logic                accept;
	logic [PW-1:0]       pos;
	logic                line_end;
	logic [NUM_CMDS-1:0] match_d;
	logic [3:0]          pins_d;
	job_kind_t           kind;
	logic                found;
	logic                ch_ok;

	assign rx.ready = !full;
	assign accept   = rx.valid && !full;

	// A full buffer wraps to position zero before the byte is stored.
	assign pos = (fill_q == FW'(BUFFER_DEPTH)) ? '0 : fill_q[PW-1:0];

	// The line ends on a line feed at a nonzero position that directly follows a carriage return.
	assign line_end = (rx.rx_byte == CH_LF) && (pos != '0) && prev_cr_q;

	// Running prefix match against each command and classification of the byte.
	always_comb begin
		match_d = match_q;
		pins_d  = pins_q;
		kind    = JOB_STORE;
		found   = 1'b0;
		ch_ok   = 1'b0;
		for (int c = 0; c < NUM_CMDS; c++) begin
			ch_ok = (rx.rx_byte == cmd_char(3'(c), pos[2:0]));
			if (pos == '0) begin
				match_d[c] = ch_ok;
			end else if (pos < PW'(cmd_len(3'(c)))) begin
				match_d[c] = match_q[c] && ch_ok;
			end
		end
		if (line_end) begin
			if (match_q[0] && pos == PW'(SENSOR_LEN + 1)) begin
				kind = JOB_SENSOR;
			end else begin
				for (int i = 0; i < NUM_PINS; i++) begin
					if (!found && match_q[i + 1] && pos == PW'(PIN_LEN + 1)) begin
						found  = 1'b1;
						pins_d = pins_q ^ (4'b0001 << i);
					end
				end
				kind = found ? JOB_PIN : JOB_ECHO;
			end
		end
	end

	// Line state registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q    <= '0;
			prev_cr_q <= 1'b0;
			match_q   <= '0;
			pins_q    <= 4'h0;
		end else if (accept) begin
			fill_q    <= line_end ? '0 : FW'(pos) + FW'(1);
			prev_cr_q <= (rx.rx_byte == CH_CR);
			match_q   <= match_d;
			pins_q    <= pins_d;
		end
	end

	assign push          = accept;
	assign push_job.kind = kind;
	assign push_job.pins = pins_d;
	assign push_job.data = rx.rx_byte;
	assign push_pos      = pos;

endmodule

`default_nettype wire

// ----- src/acld_back.sv -----
`default_nettype none

module acld_back
	import acld_pkg::*;
#(
	parameter  int BUFFER_DEPTH = BUFFER_DEPTH_DEF,
	localparam int PW           = $clog2(BUFFER_DEPTH)
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          head_valid,
	input  wire job_t          head_job,
	input  wire logic [PW-1:0] head_pos,
	output logic               pop,
	acld_ev_if.source          ev
);

	logic [7:0]  line_mem [BUFFER_DEPTH];
	logic [7:0]  rdata_q;

	back_state_t state_q;
	back_state_t state_d;
	logic [PW-1:0] idx_q;
	logic [PW-1:0] end_pos_q;
	logic [3:0]  echo_pins_q;

	logic        out_valid_q;
	ev_kind_t    out_kind_q;
	logic [7:0]  out_byte_q;
	logic        out_last_q;
	logic [3:0]  out_pins_q;

	logic        slot_free;
	logic        load;
	logic        adv;
	logic        start_echo;
	ev_kind_t    ld_kind;
	logic [7:0]  ld_byte;
	logic        ld_last;
	logic [3:0]  ld_pins;
	logic [PW-1:0] rd_addr;

	// The output register takes a new word when empty or being drained.
	assign slot_free = !out_valid_q || ev.ready;

	// Sequencer: single results for commands, a byte stream for echoed lines.
	always_comb begin
		state_d    = state_q;
		pop        = 1'b0;
		load       = 1'b0;
		adv        = 1'b0;
		start_echo = 1'b0;
		ld_kind    = EV_ECHO;
		ld_byte    = 8'h00;
		ld_last    = 1'b0;
		ld_pins    = echo_pins_q;
		unique case (state_q)
			BK_IDLE: begin
				if (head_valid) begin
					unique case (head_job.kind)
						JOB_STORE: begin
							pop = 1'b1;
						end
						JOB_SENSOR, JOB_PIN: begin
							if (slot_free) begin
								pop     = 1'b1;
								load    = 1'b1;
								ld_kind = (head_job.kind == JOB_SENSOR) ? EV_SENSOR : EV_PIN;
								ld_last = 1'b1;
								ld_pins = head_job.pins;
							end
						end
						JOB_ECHO: begin
							pop        = 1'b1;
							start_echo = 1'b1;
							state_d    = BK_ECHO;
						end
						default: begin
							pop = 1'b1;
						end
					endcase
				end
			end
			BK_ECHO: begin
				if (slot_free) begin
					load    = 1'b1;
					adv     = 1'b1;
					ld_byte = rdata_q;
					ld_last = (idx_q == end_pos_q);
					if (idx_q == end_pos_q) begin
						state_d = BK_IDLE;
					end
				end
			end
			default: begin
				state_d = BK_IDLE;
			end
		endcase
	end

	// Read address runs one step ahead when the current byte is delivered.
	always_comb begin
		if (state_q == BK_IDLE) begin
			rd_addr = '0;
		end else if (adv && idx_q != end_pos_q) begin
			rd_addr = idx_q + PW'(1);
		end else begin
			rd_addr = idx_q;
		end
	end

	// Line buffer memory with registered read.
	always_ff @(posedge clk) begin
		if (pop) begin
			line_mem[head_pos] <= head_job.data;
		end
		rdata_q <= line_mem[rd_addr];
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_IDLE;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (start_echo) begin
				idx_q <= '0;
			end else if (adv && idx_q != end_pos_q) begin
				idx_q <= idx_q + PW'(1);
			end
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (ev.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Echo context and output word payload.
	always_ff @(posedge clk) begin
		if (start_echo) begin
			end_pos_q   <= head_pos;
			echo_pins_q <= head_job.pins;
		end
		if (load) begin
			out_kind_q <= ld_kind;
			out_byte_q <= ld_byte;
			out_last_q <= ld_last;
			out_pins_q <= ld_pins;
		end
	end

	assign ev.valid      = out_valid_q;
	assign ev.event_kind = out_kind_q;
	assign ev.echo_byte  = out_byte_q;
	assign ev.last       = out_last_q;
	assign ev.pin_states = out_pins_q;

endmodule

`default_nettype wire

// ----- src/at_command_line_decoder.sv -----
// A command result reaches the output register through the job queue after its line feed.
// Throughput: one byte per cycle is taken while the two-entry job queue has room.
// An echoed line holds the back end, one echo word per cycle unless the output stalls.
// Reset clears the fill count, the command match flags, the pin bits and all handshakes.
// The line buffer memory needs no clearing: every position is written before it is read.
`default_nettype none

module at_command_line_decoder
	import acld_pkg::*;
#(
	parameter  int BUFFER_DEPTH = BUFFER_DEPTH_DEF,
	localparam int PW           = $clog2(BUFFER_DEPTH)
) (
	input  wire logic clk,
	input  wire logic arst_n,
	acld_rx_if.sink   rx,
	acld_ev_if.source ev
);

	localparam int QW = $bits(job_t) + PW;

	logic          push;
	job_t          push_job;
	logic [PW-1:0] push_pos;
	logic          full;
	logic          pop;
	logic          not_empty;
	logic [QW-1:0] head_word;
	job_t          head_job;
	logic [PW-1:0] head_pos;

	// Front end: line tracking and command classification.
	acld_front #(
		.BUFFER_DEPTH(BUFFER_DEPTH)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.rx       (rx),
		.push     (push),
		.push_job (push_job),
		.push_pos (push_pos),
		.full     (full)
	);

	// Job queue between the two ends.
	acld_fifo #(
		.WIDTH(QW)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data ({push_job, push_pos}),
		.full      (full),
		.pop       (pop),
		.pop_data  (head_word),
		.not_empty (not_empty)
	);

	assign head_job = head_word[QW-1:PW];
	assign head_pos = head_word[PW-1:0];

	// Back end: line storage and result words.
	acld_back #(
		.BUFFER_DEPTH(BUFFER_DEPTH)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (not_empty),
		.head_job   (head_job),
		.head_pos   (head_pos),
		.pop        (pop),
		.ev         (ev)
	);

endmodule

`default_nettype wire
